### rtl/pps_pkg.sv
// Shared types and constants for the preemptive priority scheduler.
`default_nettype none
package pps_pkg;

  localparam int unsigned MAX_PROCESSES_DEF = 16;
  localparam int unsigned ARR_W = 16;
  localparam int unsigned BUR_W = 16;
  localparam int unsigned PRI_W = 8;
  localparam int unsigned IDX_W = 4;
  localparam int unsigned OUT_TW = 21;

  typedef struct packed {
    logic [ARR_W-1:0] arrival_time;
    logic [BUR_W-1:0] burst_time;
    logic [PRI_W-1:0] priority_level;
    logic             last_process;
  } pps_in_t;

  typedef struct packed {
    logic [IDX_W-1:0]  process_index;
    logic [OUT_TW-1:0] completion_time;
    logic [OUT_TW-1:0] turnaround_time;
    logic [OUT_TW-1:0] waiting_time;
    logic              last_result;
  } pps_out_t;

  // One process entry as kept in the process memory.
  typedef struct packed {
    logic [ARR_W-1:0] arrival;
    logic [BUR_W-1:0] burst;
    logic [PRI_W-1:0] prio;
    logic [BUR_W-1:0] remain;
  } pps_rec_t;

  // Status from the scheduling core to the top level.
  typedef struct packed {
    logic res_valid;
    logic fin;
  } pps_stat_t;

endpackage
`default_nettype wire

### rtl/preemptive_priority_scheduler_top.sv
// Top level of the preemptive priority scheduler: load side, process memory, core, output register.
`default_nettype none
//
//  channel | signals                      | word
//  --------+------------------------------+---------------------------------------
//  in      | in_valid, in_stall, in_data  | one process: arrival, burst, priority, last
//  out     | out_valid, out_stall, out_data | one completion: index, times, last
//
//  Load takes one word per cycle; words past MAX_PROCESSES are dropped, the
//  last flag still starts the run. During the run in_stall stays high.
//  Each scheduling step is one scan of the process memory (one read per
//  cycle, n entries), then the drain and decide states, a write-back
//  (unless the step only jumps time to an arrival) and the result and emit
//  states on a completion. A step ends at a completion or an arrival, so a
//  run has at most 2*n steps. A completion waits in the core while the
//  output register is full; out_stall therefore halts the run. Reset
//  (rst, synchronous) clears the load count, done flags and time; the
//  memory needs no clearing.
//
module preemptive_priority_scheduler_top #(
  parameter int unsigned MAX_PROCESSES = pps_pkg::MAX_PROCESSES_DEF
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             in_valid,
  output logic                  in_stall,
  input  wire pps_pkg::pps_in_t in_data,
  output logic                  out_valid,
  input  wire logic             out_stall,
  output pps_pkg::pps_out_t     out_data
);

  localparam int unsigned IW = (MAX_PROCESSES > 1) ? $clog2(MAX_PROCESSES) : 1;
  localparam int unsigned CW = $clog2(MAX_PROCESSES + 1);

  logic               busy;
  logic [CW-1:0]      loaded;
  logic [CW-1:0]      loaded_next;
  logic               in_take;
  logic               store;
  logic               go;
  logic               res_take;

  pps_pkg::pps_rec_t  ld_rec;
  pps_pkg::pps_rec_t  mem_wdata;
  pps_pkg::pps_rec_t  mem_rdata;
  logic [IW-1:0]      mem_waddr;
  logic               mem_we;
  logic               mem_re;
  logic [IW-1:0]      mem_raddr;
  logic               core_we;
  logic [IW-1:0]      core_waddr;
  pps_pkg::pps_rec_t  core_wdata;
  pps_pkg::pps_stat_t stat;
  pps_pkg::pps_out_t  res;

  assign in_stall    = busy;
  assign in_take     = in_valid && !busy;
  assign store       = in_take && (loaded < CW'(MAX_PROCESSES));
  assign loaded_next = store ? loaded + 1'b1 : loaded;
  // An empty load starts nothing.
  assign go          = in_take && in_data.last_process && (loaded_next != '0);

  // Zero burst is served as one unit.
  always_comb begin
    ld_rec.arrival = in_data.arrival_time;
    ld_rec.burst   = (in_data.burst_time == '0) ? pps_pkg::BUR_W'(1) : in_data.burst_time;
    ld_rec.prio    = in_data.priority_level;
    ld_rec.remain  = ld_rec.burst;
  end

  // Load and core writes never overlap: the core only runs while busy.
  assign mem_we    = store || core_we;
  assign mem_waddr = busy ? core_waddr : loaded[IW-1:0];
  assign mem_wdata = busy ? core_wdata : ld_rec;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy   <= 1'b0;
      loaded <= '0;
    end else if (stat.fin) begin
      busy   <= 1'b0;
      loaded <= '0;
    end else if (in_take) begin
      if (go) begin
        busy   <= 1'b1;
        loaded <= loaded_next;
      end else if (in_data.last_process) begin
        loaded <= '0;
      end else begin
        loaded <= loaded_next;
      end
    end
  end

  pps_mem #(
    .DEPTH (MAX_PROCESSES),
    .AW    (IW)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  pps_core #(
    .MAX_PROCESSES (MAX_PROCESSES),
    .IW            (IW),
    .CW            (CW)
  ) u_core (
    .clk       (clk),
    .rst       (rst),
    .go        (go),
    .count     (loaded_next),
    .take      (res_take),
    .mem_re    (mem_re),
    .mem_raddr (mem_raddr),
    .mem_rdata (mem_rdata),
    .mem_we    (core_we),
    .mem_waddr (core_waddr),
    .mem_wdata (core_wdata),
    .stat      (stat),
    .res       (res)
  );

  // Output register: refills in the cycle the previous word leaves.
  assign res_take = stat.res_valid && (!out_valid || !out_stall);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_take) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_take) begin
      out_data <= res;
    end
  end

endmodule
`default_nettype wire

### rtl/pps_mem.sv
// Process memory: one write port, one read port with registered read data.
`default_nettype none
module pps_mem #(
  parameter int unsigned DEPTH = pps_pkg::MAX_PROCESSES_DEF,
  parameter int unsigned AW    = 4
) (
  input  wire logic              clk,
  input  wire logic              we,
  input  wire logic [AW-1:0]     waddr,
  input  wire pps_pkg::pps_rec_t wdata,
  input  wire logic              re,
  input  wire logic [AW-1:0]     raddr,
  output pps_pkg::pps_rec_t      rdata
);

  pps_pkg::pps_rec_t ram [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      ram[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= ram[raddr];
    end
  end

endmodule
`default_nettype wire

### rtl/pps_core.sv
// Scheduling core: scans the process memory, picks the runner, advances time, builds results.
`default_nettype none
module pps_core #(
  parameter int unsigned MAX_PROCESSES = pps_pkg::MAX_PROCESSES_DEF,
  parameter int unsigned IW = 4,
  parameter int unsigned CW = 5
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              go,
  input  wire logic [CW-1:0]     count,
  input  wire logic              take,
  output logic                   mem_re,
  output logic [IW-1:0]          mem_raddr,
  input  wire pps_pkg::pps_rec_t mem_rdata,
  output logic                   mem_we,
  output logic [IW-1:0]          mem_waddr,
  output pps_pkg::pps_rec_t      mem_wdata,
  output pps_pkg::pps_stat_t     stat,
  output pps_pkg::pps_out_t      res
);

  // Time must hold the latest arrival plus every burst.
  localparam int unsigned TW = $clog2((MAX_PROCESSES + 1) * (2 ** pps_pkg::ARR_W));

  typedef enum logic [2:0] {
    IDLE, ISSUE, DRAIN, DECIDE, UPDATE, RESULT, EMIT
  } state_t;

  state_t                     state;
  logic [CW-1:0]              n;
  logic [CW-1:0]              finished;
  logic [CW-1:0]              issue_idx;
  logic                       chk_valid;
  logic [IW-1:0]              chk_idx;
  logic [TW-1:0]              cur_time;
  logic [MAX_PROCESSES-1:0]   done;
  logic                       have_best;
  logic                       have_next;
  logic [IW-1:0]              best_idx;
  pps_pkg::pps_rec_t          best_rec;
  logic [pps_pkg::ARR_W-1:0]  next_arr;
  logic [pps_pkg::BUR_W-1:0]  run;

  logic [TW-1:0]              delta;
  logic [pps_pkg::BUR_W-1:0]  new_rem;
  logic                       arrived;

  assign delta   = TW'(next_arr) - cur_time;
  assign new_rem = best_rec.remain - run;
  assign arrived = TW'(mem_rdata.arrival) <= cur_time;

  assign mem_re    = (state == ISSUE);
  assign mem_raddr = issue_idx[IW-1:0];
  assign mem_we    = (state == UPDATE);
  assign mem_waddr = best_idx;

  always_comb begin
    mem_wdata        = best_rec;
    mem_wdata.remain = new_rem;
  end

  assign stat.res_valid = (state == EMIT);
  assign stat.fin       = (state == EMIT) && take && res.last_result;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= IDLE;
      n         <= '0;
      finished  <= '0;
      issue_idx <= '0;
      chk_valid <= 1'b0;
      cur_time  <= '0;
      done      <= '0;
      have_best <= 1'b0;
      have_next <= 1'b0;
    end else begin
      chk_valid <= (state == ISSUE);
      chk_idx   <= issue_idx[IW-1:0];

      // Fold each returning entry into the running best / next-arrival pick.
      if (chk_valid && !done[chk_idx]) begin
        if (arrived) begin
          if (!have_best || mem_rdata.prio < best_rec.prio) begin
            have_best <= 1'b1;
            best_idx  <= chk_idx;
            best_rec  <= mem_rdata;
          end
        end else if (!have_next || mem_rdata.arrival < next_arr) begin
          have_next <= 1'b1;
          next_arr  <= mem_rdata.arrival;
        end
      end

      unique case (state)
        IDLE: begin
          if (go) begin
            n         <= count;
            finished  <= '0;
            cur_time  <= '0;
            done      <= '0;
            issue_idx <= '0;
            have_best <= 1'b0;
            have_next <= 1'b0;
            state     <= ISSUE;
          end
        end
        ISSUE: begin
          issue_idx <= issue_idx + 1'b1;
          if (issue_idx + 1'b1 == n) begin
            state <= DRAIN;
          end
        end
        DRAIN: begin
          state <= DECIDE;
        end
        DECIDE: begin
          if (!have_best) begin
            // nothing ready: jump to the next arrival and rescan
            cur_time  <= TW'(next_arr);
            issue_idx <= '0;
            have_next <= 1'b0;
            state     <= ISSUE;
          end else begin
            if (have_next && delta < TW'(best_rec.remain)) begin
              run <= delta[pps_pkg::BUR_W-1:0];
            end else begin
              run <= best_rec.remain;
            end
            state <= UPDATE;
          end
        end
        UPDATE: begin
          cur_time  <= cur_time + TW'(run);
          issue_idx <= '0;
          have_best <= 1'b0;
          have_next <= 1'b0;
          if (new_rem == '0) begin
            done[best_idx] <= 1'b1;
            finished       <= finished + 1'b1;
            state          <= RESULT;
          end else begin
            state <= ISSUE;
          end
        end
        RESULT: begin
          res.process_index   <= pps_pkg::IDX_W'(best_idx);
          res.completion_time <= pps_pkg::OUT_TW'(cur_time);
          res.turnaround_time <= pps_pkg::OUT_TW'(cur_time - TW'(best_rec.arrival));
          res.waiting_time    <= pps_pkg::OUT_TW'(cur_time - TW'(best_rec.arrival)
                                                  - TW'(best_rec.burst));
          res.last_result     <= (finished == n);
          state               <= EMIT;
        end
        EMIT: begin
          if (take) begin
            state <= res.last_result ? IDLE : ISSUE;
          end
        end
        default: state <= IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire

### verif/pps_completion_checker.sv
// Checker for the preemptive priority scheduler: schedule predictor and completion compare.
`timescale 1ns / 1ps
module pps_completion_checker (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  input  logic              in_stall,
  input  pps_pkg::pps_in_t  in_data,
  input  logic              out_valid,
  input  logic              out_stall,
  input  pps_pkg::pps_out_t out_data,
  output int                fails,
  output int                outstanding,
  output int                completions_seen
);

  localparam int unsigned SLOTS = pps_pkg::MAX_PROCESSES_DEF;
  localparam logic [31:0] TIME_MASK = 32'h001F_FFFF;

  logic [pps_pkg::ARR_W-1:0] held_arrival [SLOTS];
  logic [31:0]               held_burst   [SLOTS];
  logic [pps_pkg::PRI_W-1:0] held_prio    [SLOTS];
  logic [31:0]               held_left    [SLOTS];
  bit                        held_done    [SLOTS];
  int unsigned               held_count;

  pps_pkg::pps_out_t completions_due [$];

  // Runs the held set to its end, queueing one completion per finished process.
  function automatic void schedule_load();
    logic [31:0] now, next_arr, span, ct, tat;
    int unsigned finished, best, k;
    bit have_best, have_next;
    pps_pkg::pps_out_t r;
    now = 0;
    finished = 0;
    while (finished < held_count) begin
      have_best = 0;
      have_next = 0;
      best = 0;
      next_arr = 0;
      for (k = 0; k < held_count; k++) begin
        if (held_done[k]) continue;
        if (held_arrival[k] <= now) begin
          // strict compare keeps ties on the lowest index
          if (!have_best || held_prio[k] < held_prio[best]) begin
            best = k;
            have_best = 1;
          end
        end else if (!have_next || held_arrival[k] < next_arr) begin
          next_arr = 32'(held_arrival[k]);
          have_next = 1;
        end
      end
      if (!have_best) begin
        now = have_next ? next_arr : now + 32'd1;
        continue;
      end
      // nothing can preempt before the next arrival
      span = held_left[best];
      if (have_next && (next_arr - now) < span) span = next_arr - now;
      held_left[best] -= span;
      now += span;
      if (held_left[best] == 0) begin
        held_done[best] = 1;
        finished++;
        ct = now;
        tat = ct - 32'(held_arrival[best]);
        r.process_index   = best[pps_pkg::IDX_W-1:0];
        r.completion_time = pps_pkg::OUT_TW'(ct & TIME_MASK);
        r.turnaround_time = pps_pkg::OUT_TW'(tat & TIME_MASK);
        r.waiting_time    = pps_pkg::OUT_TW'((tat - held_burst[best]) & TIME_MASK);
        r.last_result     = (finished == held_count);
        completions_due.push_back(r);
      end
    end
    held_count = 0;
    for (k = 0; k < SLOTS; k++) held_done[k] = 0;
  endfunction

  function automatic void absorb(pps_pkg::pps_in_t w);
    logic [31:0] bt;
    bt = (w.burst_time == 0) ? 32'd1 : 32'(w.burst_time);
    if (held_count < SLOTS) begin
      held_arrival[held_count] = w.arrival_time;
      held_burst[held_count]   = bt;
      held_prio[held_count]    = w.priority_level;
      held_left[held_count]    = bt;
      held_done[held_count]    = 0;
      held_count++;
    end
    if (w.last_process) schedule_load();
  endfunction

  function automatic void log_miss(string what, pps_pkg::pps_out_t want,
                                   pps_pkg::pps_out_t got);
    fails++;
    if (fails <= 10)
      $display({"%t ERROR %s: exp idx=%0d ct=%0d tat=%0d wt=%0d last=%0d,",
                " got idx=%0d ct=%0d tat=%0d wt=%0d last=%0d"},
               $time, what, want.process_index, want.completion_time,
               want.turnaround_time, want.waiting_time, want.last_result,
               got.process_index, got.completion_time, got.turnaround_time,
               got.waiting_time, got.last_result);
  endfunction

  initial begin
    fails = 0;
    outstanding = 0;
    completions_seen = 0;
    held_count = 0;
  end

  always @(posedge clk) begin
    pps_pkg::pps_out_t want;
    if (rst) begin
      held_count = 0;
      for (int k = 0; k < SLOTS; k++) held_done[k] = 0;
      completions_due.delete();
    end else begin
      if (out_valid && !out_stall) begin
        completions_seen++;
        if (completions_due.size() == 0) begin
          log_miss("unexpected completion word", '0, out_data);
        end else begin
          want = completions_due.pop_front();
          if (want.process_index   !== out_data.process_index   ||
              want.completion_time !== out_data.completion_time ||
              want.turnaround_time !== out_data.turnaround_time ||
              want.waiting_time    !== out_data.waiting_time    ||
              want.last_result     !== out_data.last_result)
            log_miss("completion word differs", want, out_data);
        end
      end
      if (in_valid && !in_stall) absorb(in_data);
    end
    outstanding <= completions_due.size();
  end

endmodule

### verif/tb_preemptive_priority_scheduler_top.sv
// Testbench top for the preemptive priority scheduler: stimulus, back-pressure and verdict.
`timescale 1ns / 1ps
module tb_preemptive_priority_scheduler_top;

  localparam int LIMIT_CYCLES = 400000;   // far above the slowest legal run
  localparam int TAIL_CYCLES = 64;        // settle time after the last completion
  localparam int WORD_TARGET = 460;

  logic              clk = 1'b0;
  logic              rst;
  logic              in_valid;
  logic              in_stall;
  pps_pkg::pps_in_t  in_data;
  logic              out_valid;
  logic              out_stall;
  pps_pkg::pps_out_t out_data;

  int fail_count;
  int pending;
  int completions_seen;
  int words_sent = 0;
  int loads_sent = 0;
  bit calm = 0;        // when set, neither side inserts gaps

  always #10 clk = ~clk;

  preemptive_priority_scheduler_top dut (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data)
  );

  pps_completion_checker u_checker (
    .clk             (clk),
    .rst             (rst),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_data         (in_data),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_data        (out_data),
    .fails           (fail_count),
    .outstanding     (pending),
    .completions_seen(completions_seen)
  );

  // Present one process word after a random gap and hold it until accepted.
  // Returns in the time step of the accepting edge.
  task automatic send_word(input pps_pkg::pps_in_t w);
    int gap;
    gap = calm ? 0 : $urandom_range(0, 3);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= w;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    words_sent++;
  endtask

  // Sender goes quiet until every predicted completion has been taken.
  // pending is updated by NBA, so the first edge below sees the latest pushes.
  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  function automatic pps_pkg::pps_in_t proc_word(int arr, int bur, int pri, bit last);
    pps_pkg::pps_in_t w;
    w.arrival_time   = arr[pps_pkg::ARR_W-1:0];
    w.burst_time     = bur[pps_pkg::BUR_W-1:0];
    w.priority_level = pri[pps_pkg::PRI_W-1:0];
    w.last_process   = last;
    return w;
  endfunction

  // Random load: mostly 1..16 processes, sometimes past the table size so the
  // tail is dropped (its last flag still starts the run). Arrivals are either
  // clustered, which gives heavy preemption, or spread over the whole 16-bit range.
  task automatic send_random_load();
    int n, k, arr_top, pri_top;
    pps_pkg::pps_in_t w;
    n = ($urandom_range(0, 9) == 0) ? $urandom_range(17, 20) : $urandom_range(1, 16);
    arr_top = $urandom_range(0, 1) ? 65535 : $urandom_range(0, 60);
    pri_top = $urandom_range(0, 1) ? 255 : 3;     // narrow span forces ties
    calm = ($urandom_range(0, 4) == 0);
    for (k = 0; k < n; k++) begin
      w.arrival_time = pps_pkg::ARR_W'($urandom_range(0, arr_top));
      case ($urandom_range(0, 7))
        0:       w.burst_time = '0;               // zero burst runs as one unit
        1:       w.burst_time = pps_pkg::BUR_W'($urandom_range(0, 65535));
        default: w.burst_time = pps_pkg::BUR_W'($urandom_range(1, 30));
      endcase
      w.priority_level = pps_pkg::PRI_W'($urandom_range(0, pri_top));
      w.last_process   = (k == n - 1);
      send_word(w);
    end
    loads_sent++;
  endtask

  // Receiver: a random hold before each completion word, none while calm.
  initial begin
    int hold;
    out_stall <= 1'b0;
    @(posedge clk);
    forever begin
      hold = calm ? 0 : $urandom_range(0, 3);
      if (hold > 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(posedge clk);
      end
      out_stall <= 1'b0;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
    end
  end

  initial begin
    int k;
    rst      <= 1'b1;
    in_valid <= 1'b0;
    in_data  <= '0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // Directed: smallest and largest single processes.
    send_word(proc_word(0, 1, 0, 1'b1));
    send_word(proc_word(65535, 65535, 255, 1'b1));
    loads_sent += 2;

    // Zero burst, equal priority tie (lower index first), preemption by a
    // more urgent arrival, then an idle gap before the final arrival.
    send_word(proc_word(10, 0, 2, 1'b0));
    send_word(proc_word(10, 3, 2, 1'b0));
    send_word(proc_word(12, 4, 0, 1'b0));
    send_word(proc_word(40, 2, 7, 1'b1));
    loads_sent++;

    // Full table of maximal processes pushes times to their top value; the
    // two extra words are dropped and the dropped one still starts the run.
    for (k = 0; k < 18; k++)
      send_word(proc_word(65535, 65535, (k * 37) % 256, k == 17));
    loads_sent++;

    wait_drained();

    // Random part, with a full drain every eighth load.
    while (words_sent < WORD_TARGET) begin
      send_random_load();
      if (loads_sent % 8 == 0) wait_drained();
    end

    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("%0d process words in %0d loads, %0d completions checked", words_sent,
             loads_sent, completions_seen);
    $display("covered ties, preemption, idle gaps, zero bursts, table overflow, full ranges");
    if (fail_count == 0) begin
      $display("preemptive_priority_scheduler_top: match");
    end else begin
      $display("preemptive_priority_scheduler_top: mismatch");
    end
    $finish;
  end

  // Watchdog.
  initial begin
    #(LIMIT_CYCLES * 20);
    $display("preemptive_priority_scheduler_top: mismatch");
    $finish;
  end

endmodule
